FILE: sv/event_priority_queue_defines.svh
// Assertion macros for the event priority queue.
`ifndef EVENT_PRIORITY_QUEUE_DEFINES_SVH
`define EVENT_PRIORITY_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define EPQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EPQ_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
  `EPQ_ASSERT(label, clk, rst_n, (lhs) |-> (rhs), msg)
`else
`define EPQ_ASSERT(label, clk, rst_n, prop, msg)
`define EPQ_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg)
`endif
`endif

FILE: sv/epq_pkg.sv
`default_nettype none
package epq_pkg;
  localparam int Capacity = 64;
  localparam int RefBits  = 16;
  localparam int IdxBits  = $clog2(Capacity);
  localparam int CntBits  = $clog2(Capacity + 1);
  localparam int TimeBits = 48;
  localparam int SeqBits  = 32;
  localparam int RowBits  = TimeBits + SeqBits + RefBits;

  typedef enum logic [2:0] {
    OP_SCHED  = 3'd0,
    OP_CANCEL = 3'd1,
    OP_DEQ    = 3'd2,
    OP_PEEK   = 3'd3,
    OP_QUERY  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_WAIT, S_FINISH, S_OUT
  } fsm_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input word
    logic scan_clr;  // reset scan index and best
    logic scan_step; // issue read / compare
    logic finish;    // apply update and build result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last; // last address issued
  } stat_t;
endpackage
`default_nettype wire

FILE: sv/epq_ram.sv
`default_nettype none
module epq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: sv/epq_ctrl.sv
`default_nettype none
module epq_ctrl import epq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  input  wire stat_t stat_i,
  output cmd_t      cmd_o
);
  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) state_d = S_WAIT;
      end
      S_WAIT: begin
        cmd_o.scan_step = 1'b1; // compare of last read
        state_d = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          in_stall_o = 1'b0;
          state_d    = S_IDLE;
          if (in_valid_i) begin
            cmd_o.load     = 1'b1;
            cmd_o.scan_clr = 1'b1;
            state_d        = S_SCAN;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: sv/epq_dp.sv
`default_nettype none
module epq_dp import epq_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output stat_t                    stat_o,
  input  wire logic [2:0]          opcode_i,
  input  wire logic [TimeBits-1:0] current_time_i,
  input  wire logic [TimeBits-1:0] delay_i,
  input  wire logic [RefBits-1:0]  event_ref_i,
  input  wire logic [TimeBits-1:0] key_time_i,
  input  wire logic [SeqBits-1:0]  key_seq_i,
  output logic [1:0]               status_o,
  output logic [RefBits-1:0]       out_ref_o,
  output logic [TimeBits-1:0]      out_time_o,
  output logic [SeqBits-1:0]       out_seq_o,
  output logic [6:0]               occupancy_o,
  output logic [6:0]               peak_occupancy_o,
  output logic [31:0]              total_scheduled_o,
  output logic [31:0]              total_removed_o,
  output logic [31:0]              total_cancelled_o
);
  // captured word
  logic [2:0]          op_q;
  logic [TimeBits-1:0] st_q;  // saturated fire time
  logic [RefBits-1:0]  ref_q;
  logic [TimeBits-1:0] kt_q;
  logic [SeqBits-1:0]  ks_q;
  logic [TimeBits:0]   sum;

  assign sum = {1'b0, current_time_i} + {1'b0, delay_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      st_q  <= sum[TimeBits] ? {TimeBits{1'b1}} : sum[TimeBits-1:0];
      ref_q <= event_ref_i;
      kt_q  <= key_time_i;
      ks_q  <= key_seq_i;
    end
  end

  // scan: raddr issued, data in the next cycle
  logic [IdxBits-1:0] raddr_q;
  logic               rd_vld_q;
  logic [IdxBits-1:0] rd_idx_q;
  logic [RowBits-1:0] rdata;
  logic [Capacity-1:0] valid_q;
  logic               issued_q;

  assign stat_o.scan_last = (raddr_q == IdxBits'(Capacity - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raddr_q  <= '0;
      rd_vld_q <= 1'b0;
      issued_q <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      raddr_q  <= '0;
      rd_vld_q <= 1'b0;
      issued_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      rd_vld_q <= !issued_q;
      rd_idx_q <= raddr_q;
      if (stat_o.scan_last) issued_q <= 1'b1;
      else raddr_q <= raddr_q + 1'b1;
    end else begin
      rd_vld_q <= 1'b0;
    end
  end

  logic [TimeBits-1:0] r_time;
  logic [SeqBits-1:0]  r_seq;
  assign r_time = rdata[RowBits-1 -: TimeBits];
  assign r_seq  = rdata[RefBits +: SeqBits];

  // best match
  logic               hit_q, free_hit_q;
  logic [IdxBits-1:0] hit_idx_q, free_idx_q;
  logic [RowBits-1:0] hit_row_q;
  logic               is_min_op, better;
  logic [TimeBits-1:0] h_time;
  logic [SeqBits-1:0]  h_seq;
  logic [RefBits-1:0]  h_ref;
  assign {h_time, h_seq, h_ref} = hit_row_q;
  assign is_min_op = (op_q == OP_DEQ) || (op_q == OP_PEEK);

  always_comb begin
    better = 1'b0;
    if (valid_q[rd_idx_q]) begin
      if (is_min_op)
        better = !hit_q || (r_time < h_time) || (r_time == h_time && r_seq < h_seq);
      else
        better = !hit_q && (r_time == kt_q) && (r_seq == ks_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      free_hit_q <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      hit_q <= 1'b0;
      free_hit_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (better) begin
        hit_q     <= 1'b1;
        hit_idx_q <= rd_idx_q;
        hit_row_q <= rdata;
      end
      if (!free_hit_q && !valid_q[rd_idx_q]) begin
        free_hit_q <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
    end
  end

  // counters and update
  logic [SeqBits-1:0] next_seq_q;
  logic [CntBits-1:0] held_q, peak_q;
  logic [31:0]        sched_q, rem_q, canc_q;
  logic               we;
  logic [RowBits-1:0] wdata;
  logic               do_sched, found;

  assign do_sched = cmd_i.finish && (op_q == OP_SCHED) && free_hit_q;
  assign found    = hit_q && (op_q == OP_CANCEL || op_q == OP_DEQ ||
                              op_q == OP_PEEK || op_q == OP_QUERY);
  assign we       = do_sched;
  assign wdata    = {st_q, next_seq_q, ref_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      next_seq_q <= '0;
      held_q     <= '0;
      peak_q     <= '0;
      sched_q    <= '0;
      rem_q      <= '0;
      canc_q     <= '0;
    end else if (cmd_i.finish) begin
      if (do_sched) begin
        valid_q[free_idx_q] <= 1'b1;
        next_seq_q <= next_seq_q + 1'b1;
        held_q     <= held_q + 1'b1;
        sched_q    <= sched_q + 1'b1;
        if (peak_q == held_q) peak_q <= held_q + 1'b1;
      end else if (found && (op_q == OP_CANCEL || op_q == OP_DEQ)) begin
        valid_q[hit_idx_q] <= 1'b0;
        held_q <= held_q - 1'b1;
        rem_q  <= rem_q + 1'b1;
        if (op_q == OP_CANCEL) canc_q <= canc_q + 1'b1;
      end
    end
  end

  // result word held until taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (op_q == OP_SCHED) begin
        status_o   <= free_hit_q ? ST_OK : ST_FULL;
        out_ref_o  <= free_hit_q ? ref_q : '0;
        out_time_o <= free_hit_q ? st_q : '0;
        out_seq_o  <= free_hit_q ? next_seq_q : '0;
      end else begin
        status_o   <= found ? ST_OK : ST_NONE;
        out_ref_o  <= found ? h_ref : '0;
        out_time_o <= found ? h_time : '0;
        out_seq_o  <= found ? h_seq : '0;
      end
    end
  end

  assign occupancy_o       = 7'(held_q);
  assign peak_occupancy_o  = 7'(peak_q);
  assign total_scheduled_o = sched_q;
  assign total_removed_o   = rem_q;
  assign total_cancelled_o = canc_q;

  epq_ram #(.Width(RowBits), .Depth(Capacity)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (free_idx_q),
    .wdata_i (wdata),
    .raddr_i (raddr_q),
    .rdata_o (rdata)
  );
endmodule
`default_nettype wire

FILE: sv/event_priority_queue.sv
// channel | valid     | stall     | words
// in      | in_valid  | in_stall  | opcode, current_time, delay, event_ref, key_time, key_seq
// out     | out_valid | out_stall | status, out_ref, out_time, out_seq, counters
//
// Each word passes a scan of the entry RAM, one row per cycle through its
// single registered read port, a compare of the last row, an update step and
// the result step.
// The next word is taken in the cycle the result is taken.
// rst_ni clears valid bits and counters at once; RAM rows need no clearing.
// A stalled result holds, and input stays stalled until it is taken.
`default_nettype none
`include "event_priority_queue_defines.svh"
module event_priority_queue import epq_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [2:0]          opcode_i,
  input  wire logic [TimeBits-1:0] current_time_i,
  input  wire logic [TimeBits-1:0] delay_i,
  input  wire logic [RefBits-1:0]  event_ref_i,
  input  wire logic [TimeBits-1:0] key_time_i,
  input  wire logic [SeqBits-1:0]  key_seq_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [1:0]               status_o,
  output logic [RefBits-1:0]       out_ref_o,
  output logic [TimeBits-1:0]      out_time_o,
  output logic [SeqBits-1:0]       out_seq_o,
  output logic [6:0]               occupancy_o,
  output logic [6:0]               peak_occupancy_o,
  output logic [31:0]              total_scheduled_o,
  output logic [31:0]              total_removed_o,
  output logic [31:0]              total_cancelled_o
);
  localparam logic [6:0] OccMax = 7'(Capacity);

  cmd_t  cmd;
  stat_t stat;
  logic  full_rpt;

  epq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i (stat), .cmd_o (cmd)
  );

  epq_dp u_dp (
    .clk_i, .rst_ni, .cmd_i (cmd), .stat_o (stat),
    .opcode_i, .current_time_i, .delay_i, .event_ref_i, .key_time_i, .key_seq_i,
    .status_o, .out_ref_o, .out_time_o, .out_seq_o, .occupancy_o,
    .peak_occupancy_o, .total_scheduled_o, .total_removed_o, .total_cancelled_o
  );

  assign full_rpt = out_valid_o && (status_o == ST_FULL);

  // occupancy never exceeds capacity and peak tracks it
  `EPQ_ASSERT(a_occ_cap, clk_i, rst_ni, occupancy_o <= OccMax, "occupancy over capacity")
  `EPQ_ASSERT(a_peak, clk_i, rst_ni, peak_occupancy_o >= occupancy_o, "peak below occupancy")
  // input opens beside a valid result only when that result is being taken
  `EPQ_ASSERT_IMPL(a_no_accept, clk_i, rst_ni, !in_stall_o && out_valid_o, !out_stall_i, "overlap")
  // a full report leaves occupancy at capacity
  `EPQ_ASSERT_IMPL(a_full, clk_i, rst_ni, full_rpt, occupancy_o == OccMax, "full with room")
endmodule
`default_nettype wire

FILE: sim/tb_event_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_event_priority_queue;
  import epq_pkg::*;

  localparam logic [2:0]  OP_BAD5 = 3'd5;
  localparam logic [2:0]  OP_BAD6 = 3'd6;
  localparam logic [2:0]  OP_BAD7 = 3'd7;
  localparam logic [47:0] TMAX = '1;
  localparam logic [31:0] SMAX = '1;

  // one input word
  typedef struct {
    logic [2:0]          op;
    logic [TimeBits-1:0] now;
    logic [TimeBits-1:0] dly;
    logic [RefBits-1:0]  eref;
    logic [TimeBits-1:0] kt;
    logic [SeqBits-1:0]  ks;
    bit                  chk;   // typed expectation present
    status_e             st;
    logic [RefBits-1:0]  xref;
    logic [TimeBits-1:0] xtime;
    logic [SeqBits-1:0]  xseq;
  } word_t;

  // one result word
  typedef struct {
    logic [1:0]          st;
    logic [RefBits-1:0]  oref;
    logic [TimeBits-1:0] otime;
    logic [SeqBits-1:0]  oseq;
    logic [6:0]          occ;
    logic [6:0]          peak;
    logic [31:0]         n_sched;
    logic [31:0]         n_rem;
    logic [31:0]         n_can;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  logic [2:0] opcode = '0;
  logic [TimeBits-1:0] cur_time = '0, delay = '0, key_time = '0;
  logic [RefBits-1:0] event_ref = '0;
  logic [SeqBits-1:0] key_seq = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  logic [1:0] status_o;
  logic [RefBits-1:0] out_ref_o;
  logic [TimeBits-1:0] out_time_o;
  logic [SeqBits-1:0] out_seq_o;
  logic [6:0] occupancy_o, peak_occupancy_o;
  logic [31:0] total_scheduled_o, total_removed_o, total_cancelled_o;

  // typed expectation riding along with the driven word
  bit cur_chk = 0;
  word_t cur_w;

  always #2 clk_i = ~clk_i;

  event_priority_queue dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o,
    .opcode_i(opcode), .current_time_i(cur_time), .delay_i(delay),
    .event_ref_i(event_ref), .key_time_i(key_time), .key_seq_i(key_seq),
    .out_valid_o, .out_stall_i(out_stall),
    .status_o, .out_ref_o, .out_time_o, .out_seq_o,
    .occupancy_o, .peak_occupancy_o,
    .total_scheduled_o, .total_removed_o, .total_cancelled_o
  );

  // shadow copy of the event list
  bit                  sh_valid [Capacity];
  logic [TimeBits-1:0] sh_time  [Capacity];
  logic [SeqBits-1:0]  sh_seq   [Capacity];
  logic [RefBits-1:0]  sh_ref   [Capacity];
  logic [SeqBits-1:0]  sh_next;
  logic [6:0]          sh_held, sh_peak;
  logic [31:0]         sh_sched, sh_rem, sh_can;

  res_t expect_q[$];
  int   errors = 0;
  int   tx_pct = 0, rx_pct = 0;
  int   hold_req = 0, hold_cnt = 0;

  // apply one word to the shadow list, return the result it produces
  function automatic res_t queue_op(word_t w);
    res_t r;
    int k;
    logic [TimeBits:0] sum;
    r = '{st: ST_NONE, default: '0};
    k = -1;
    if (w.op == OP_SCHED) begin
      for (int i = 0; i < Capacity; i++)
        if (k < 0 && !sh_valid[i]) k = i;
      if (k < 0) begin
        r.st = ST_FULL;
      end else begin
        sum = {1'b0, w.now} + {1'b0, w.dly};
        sh_valid[k] = 1; sh_time[k] = sum[TimeBits] ? TMAX : sum[TimeBits-1:0];
        sh_seq[k] = sh_next; sh_ref[k] = w.eref;
        sh_next++; sh_held++; sh_sched++;
        if (sh_peak < sh_held) sh_peak = sh_held;
        r.st = ST_OK; r.oref = w.eref; r.otime = sh_time[k]; r.oseq = sh_seq[k];
      end
    end else if (w.op == OP_CANCEL || w.op == OP_QUERY) begin
      for (int i = 0; i < Capacity; i++)
        if (k < 0 && sh_valid[i] && sh_time[i] == w.kt && sh_seq[i] == w.ks) k = i;
    end else if (w.op == OP_DEQ || w.op == OP_PEEK) begin
      for (int i = 0; i < Capacity; i++)
        if (sh_valid[i] && (k < 0 || sh_time[i] < sh_time[k] ||
            (sh_time[i] == sh_time[k] && sh_seq[i] < sh_seq[k]))) k = i;
    end
    if (w.op != OP_SCHED && k >= 0) begin
      r.st = ST_OK; r.oref = sh_ref[k]; r.otime = sh_time[k]; r.oseq = sh_seq[k];
      if (w.op == OP_CANCEL || w.op == OP_DEQ) begin
        sh_valid[k] = 0; sh_held--; sh_rem++;
        if (w.op == OP_CANCEL) sh_can++;
      end
    end
    r.occ = sh_held; r.peak = sh_peak;
    r.n_sched = sh_sched; r.n_rem = sh_rem; r.n_can = sh_can;
    return r;
  endfunction

  // accept side predicts, result side checks against the oldest prediction
  always @(posedge clk_i) begin
    res_t p, a;
    word_t w;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        w = cur_w;
        w.op = opcode; w.now = cur_time; w.dly = delay; w.eref = event_ref;
        w.kt = key_time; w.ks = key_seq;
        p = queue_op(w);
        if (cur_chk && (p.st != w.st || p.oref != w.xref || p.otime != w.xtime ||
                        p.oseq != w.xseq)) begin
          errors++;
          if (errors <= 10)
            $display("directed op %0d: typed st=%0d ref=%h t=%h s=%h, ",
                     "predicted st=%0d ref=%h t=%h s=%h",
                     w.op, w.st, w.xref, w.xtime, w.xseq, p.st, p.oref, p.otime, p.oseq);
        end
        expect_q.push_back(p);
      end
      if (out_valid_o && !out_stall) begin
        a = '{status_o, out_ref_o, out_time_o, out_seq_o, occupancy_o, peak_occupancy_o,
              total_scheduled_o, total_removed_o, total_cancelled_o};
        if (expect_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word: %p", a);
        end else begin
          p = expect_q.pop_front();
          if (a != p) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", p, a);
          end
        end
      end
    end
  end

  // receiver stall, with an optional long hold counted here
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  // drive one word and wait until it is taken; caller sits just after an edge
  task automatic send_word(word_t w);
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    opcode <= w.op; cur_time <= w.now; delay <= w.dly; event_ref <= w.eref;
    key_time <= w.kt; key_seq <= w.ks;
    cur_chk <= w.chk; cur_w <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic logic [TimeBits-1:0] rand_time();
    case ($urandom_range(3))
      0: return TimeBits'({$urandom, $urandom});
      1: return TimeBits'($urandom_range(1000));
      2: return TMAX - TimeBits'($urandom_range(3));
      default: return {16'($urandom), 32'($urandom)} >> $urandom_range(47);
    endcase
  endfunction

  function automatic word_t row(logic [2:0] op, logic [47:0] now, logic [47:0] dly,
                                logic [15:0] eref, logic [47:0] kt, logic [31:0] ks,
                                bit chk, status_e st, logic [15:0] xref,
                                logic [47:0] xtime, logic [31:0] xseq);
    return '{op, now, dly, eref, kt, ks, chk, st, xref, xtime, xseq};
  endfunction

  // random word, lookups mostly aimed at live entries; fill biases toward schedules
  function automatic word_t rand_word(bit fill);
    word_t w;
    int pick, live[$];
    w = row(OP_SCHED, rand_time(), rand_time(), 16'($urandom), rand_time(), $urandom,
            0, ST_OK, 0, 0, 0);
    if ($urandom_range(1)) w.dly = TimeBits'($urandom_range(50));
    for (int i = 0; i < Capacity; i++) if (sh_valid[i]) live.push_back(i);
    pick = fill ? ($urandom_range(9) < 9 ? 0 : 50) : $urandom_range(99);
    if (pick < 40) w.op = OP_SCHED;
    else if (pick < 58) w.op = OP_CANCEL;
    else if (pick < 70) w.op = OP_QUERY;
    else if (pick < 88) w.op = OP_DEQ;
    else if (pick < 96) w.op = OP_PEEK;
    else w.op = 3'($urandom_range(5, 7));
    if ((w.op == OP_CANCEL || w.op == OP_QUERY) && live.size() > 0 &&
        $urandom_range(9) < 8) begin
      pick = live[$urandom_range(live.size() - 1)];
      w.kt = sh_time[pick]; w.ks = sh_seq[pick];
      if ($urandom_range(9) == 0) w.ks ^= 32'(1) << $urandom_range(31);
    end
    return w;
  endfunction

  initial begin
    word_t dir_q[$];
    int pct_tx[4] = '{0, 56, 0, 17};
    int pct_rx[4] = '{0, 0, 56, 17};

    for (int i = 0; i < Capacity; i++) sh_valid[i] = 0;
    sh_next = '0; sh_held = '0; sh_peak = '0;
    sh_sched = '0; sh_rem = '0; sh_can = '0;

    // directed: empty store, unknown codes, saturation, lookups
    dir_q.push_back(row(OP_DEQ, 0, 0, 0, 0, 0, 1, ST_NONE, 0, 0, 0));
    dir_q.push_back(row(OP_PEEK, TMAX, TMAX, '1, TMAX, SMAX, 1, ST_NONE, 0, 0, 0));
    dir_q.push_back(row(OP_QUERY, 0, 0, 0, 0, 0, 1, ST_NONE, 0, 0, 0));
    dir_q.push_back(row(OP_CANCEL, 0, 0, 0, TMAX, SMAX, 1, ST_NONE, 0, 0, 0));
    dir_q.push_back(row(OP_BAD5, 0, 0, '1, 0, 0, 1, ST_NONE, 0, 0, 0));
    dir_q.push_back(row(OP_BAD6, TMAX, 0, 0, 0, 0, 1, ST_NONE, 0, 0, 0));
    dir_q.push_back(row(OP_BAD7, 0, TMAX, '1, TMAX, SMAX, 1, ST_NONE, 0, 0, 0));
    dir_q.push_back(row(OP_SCHED, TMAX, TMAX, '1, 0, 0, 1, ST_OK, '1, TMAX, 0));
    dir_q.push_back(row(OP_SCHED, 0, 0, 0, 0, 0, 1, ST_OK, 0, 0, 1));
    dir_q.push_back(row(OP_SCHED, TMAX, 0, 16'h1234, 0, 0, 1, ST_OK, 16'h1234, TMAX, 2));
    dir_q.push_back(row(OP_SCHED, 0, TMAX, 16'ha5a5, 0, 0, 1, ST_OK, 16'ha5a5, TMAX, 3));
    dir_q.push_back(row(OP_SCHED, 5, 5, 16'h5a5a, 0, 0, 1, ST_OK, 16'h5a5a, 10, 4));
    dir_q.push_back(row(OP_SCHED, 48'h8000_0000_0000, 48'h7fff_ffff_ffff, 7, 0, 0,
                        1, ST_OK, 7, TMAX, 5));
    dir_q.push_back(row(OP_PEEK, 0, 0, 0, 0, 0, 1, ST_OK, 0, 0, 1));
    dir_q.push_back(row(OP_QUERY, 0, 0, 0, TMAX, 2, 1, ST_OK, 16'h1234, TMAX, 2));
    dir_q.push_back(row(OP_CANCEL, 0, 0, 0, TMAX, 0, 1, ST_OK, '1, TMAX, 0));
    dir_q.push_back(row(OP_QUERY, 0, 0, 0, TMAX, 0, 1, ST_NONE, 0, 0, 0));
    dir_q.push_back(row(OP_CANCEL, 0, 0, 0, 10, 4, 0, ST_OK, 0, 0, 0));
    dir_q.push_back(row(OP_DEQ, 0, 0, 0, 0, 0, 1, ST_OK, 0, 0, 1));
    // remaining entries tie on time: lower sequence comes out first
    dir_q.push_back(row(OP_DEQ, 0, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0));
    dir_q.push_back(row(OP_DEQ, 0, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0));
    dir_q.push_back(row(OP_DEQ, 0, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0));
    dir_q.push_back(row(OP_DEQ, 0, 0, 0, 0, 0, 1, ST_NONE, 0, 0, 0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_q[i]) send_word(dir_q[i]);

    for (int ph = 0; ph < 4; ph++) begin
      // sender pause until everything in flight has come back
      in_valid <= 1'b0;
      while (expect_q.size() != 0) @(posedge clk_i);
      @(posedge clk_i);
      tx_pct = pct_tx[ph];
      rx_pct = pct_rx[ph];
      if (ph == 1) hold_req = 800;  // long receiver hold while words keep coming
      for (int n = 0; n < 400; n++) begin
        // bursts of schedules drive the store to full now and then
        send_word(rand_word((n % 200) < 80 && ph != 2));
      end
    end
    in_valid <= 1'b0;
    while (expect_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expect_q.size() == 0) begin
      $display("tb_event_priority_queue: done, clean");
    end else begin
      $display("tb_event_priority_queue: done, errors");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("tb_event_priority_queue: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
